FILE: sv/drs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running statistics sequencer package
// Shared widths, codes, state types and the request/result structs that pass
// between the top level and the iterative arithmetic core.
// ----------------------------------------------------------------------------
package drs_pkg;

    localparam int CNT_W  = 16;
    localparam int FRAC   = 16;
    localparam int FREQ_W = 32;
    localparam int MEAN_W = 48;
    localparam int SQ_W   = 64;
    localparam int STD_W  = 48;

    // Width of the shared add/subtract unit in the core.
    localparam int UW     = 50;

    // Input item kinds.
    localparam logic [1:0] MODE_SIGNAL = 2'd0;
    localparam logic [1:0] MODE_PUMP   = 2'd1;
    localparam logic [1:0] MODE_FLIP   = 2'd2;
    localparam logic [1:0] MODE_ABORT  = 2'd3;

    // Result event codes.
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_FLIP     = 2'd1;
    localparam logic [1:0] EV_DONE     = 2'd2;
    localparam logic [1:0] EV_ABORTED  = 2'd3;

    // Final channel codes.
    localparam logic [1:0] FINAL_SIGNAL = 2'd0;
    localparam logic [1:0] FINAL_PUMP   = 2'd1;

    // Register indexes.
    localparam logic REG_TARGET = 1'b0;
    localparam logic REG_FINAL  = 1'b1;

    typedef enum logic [1:0] {
        PH_READING,
        PH_WAITING,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_DIVM,
        CS_MEAN,
        CS_MUL,
        CS_ACC,
        CS_DIVV,
        CS_SQRT,
        CS_DONE
    } t_core_st;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_CALC,
        TS_EMIT
    } t_top_st;

    typedef struct packed {
        logic signed [MEAN_W-1:0] avg;
        logic        [SQ_W-1:0]   sq;
        logic        [CNT_W-1:0]  cnt;
        logic signed [FREQ_W-1:0] freq;
    } t_core_req;

    typedef struct packed {
        logic signed [MEAN_W-1:0] avg;
        logic        [SQ_W-1:0]   sq;
        logic        [STD_W-1:0]  stdev;
    } t_core_res;

endpackage

FILE: sv/drs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running statistics arithmetic core
// Updates one channel's mean and squared deviation sum and recomputes its
// standard deviation, using one shared add/subtract unit for the divisions,
// the shift-add multiply and the square root.
// ----------------------------------------------------------------------------
module drs_core import drs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_core_req i_req,
    output logic      o_done,
    output t_core_res o_res
);

    t_core_st r_st, n_st;
    logic [6:0]               r_cnt;
    logic signed [MEAN_W-1:0] r_x;
    logic signed [MEAN_W-1:0] r_avg;
    logic [SQ_W-1:0]          r_sq;
    logic [CNT_W-1:0]         r_n;
    logic                     r_neg;
    logic [MEAN_W-1:0]        r_dmag;
    logic [MEAN_W-1:0]        r_emag;
    logic                     r_skip;
    logic [63:0]              r_quo;
    logic [CNT_W-1:0]         r_rem;
    logic [CNT_W-1:0]         r_div;
    logic [95:0]              r_acc;
    logic [79:0]              r_sqn;
    logic [40:0]              r_sqrem;
    logic [39:0]              r_root;
    logic [STD_W-1:0]         r_std;

    // Shared add/subtract unit.
    logic [UW-1:0] w_a, w_b;
    logic          w_sub;
    logic [UW:0]   w_sum;
    logic          w_ge;
    logic [CNT_W:0] w_div_s;
    logic [42:0]   w_sq_s;
    logic [41:0]   w_trial;
    logic [63:0]   w_quo_nx;
    logic          w_last;

    assign w_div_s  = {r_rem, r_quo[63]};
    assign w_sq_s   = {r_sqrem, r_sqn[79:78]};
    assign w_trial  = {r_root, 2'b01};
    assign w_sum    = {1'b0, w_a} + {1'b0, (w_sub ? ~w_b : w_b)} + (UW+1)'(w_sub);
    assign w_ge     = w_sum[UW];
    assign w_quo_nx = {r_quo[62:0], w_ge};
    assign w_last   = (r_cnt == 7'd1);

    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_sub = 1'b0;
        case (r_st)
            CS_DIVM, CS_DIVV: begin
                w_a   = UW'(w_div_s);
                w_b   = UW'(r_div);
                w_sub = 1'b1;
            end
            CS_MUL: begin
                w_a = UW'(r_acc[95:48]);
                w_b = UW'(r_emag);
            end
            CS_SQRT: begin
                w_a   = UW'(w_sq_s);
                w_b   = UW'(w_trial);
                w_sub = 1'b1;
            end
            default: begin
                w_sub = 1'b0;
            end
        endcase
    end

    // Delta of the new reading against the current mean.
    logic signed [MEAN_W-1:0] w_x_in;
    logic [MEAN_W:0]          w_delta;
    logic [MEAN_W:0]          w_dneg;
    assign w_x_in  = {i_req.freq, {FRAC{1'b0}}};
    assign w_delta = {w_x_in[MEAN_W-1], w_x_in} - {i_req.avg[MEAN_W-1], i_req.avg};
    assign w_dneg  = -w_delta;

    // New mean with saturation, and the deviation from it.
    logic [49:0]       w_qs, w_m50, w_e50, w_eneg;
    logic [MEAN_W-1:0] w_m;
    logic              w_epos, w_eneg_s;
    assign w_qs  = r_neg ? -{2'b00, r_quo[MEAN_W-1:0]} : {2'b00, r_quo[MEAN_W-1:0]};
    assign w_m50 = {{2{r_avg[MEAN_W-1]}}, r_avg} + w_qs;

    always_comb begin
        if (w_m50[49:47] == 3'b000 || w_m50[49:47] == 3'b111) begin
            w_m = w_m50[MEAN_W-1:0];
        end else if (w_m50[49]) begin
            w_m = {1'b1, {(MEAN_W-1){1'b0}}};
        end else begin
            w_m = {1'b0, {(MEAN_W-1){1'b1}}};
        end
    end

    assign w_e50    = {{2{r_x[MEAN_W-1]}}, r_x} - {{2{w_m[MEAN_W-1]}}, w_m};
    assign w_eneg   = -w_e50;
    assign w_eneg_s = w_e50[49];
    assign w_epos   = !w_e50[49] && (w_e50 != '0);

    // Scaled product added into the saturating sum.
    logic [SQ_W-1:0] w_addv;
    logic [SQ_W:0]   w_sq65;
    logic [SQ_W-1:0] w_sq_new;
    assign w_addv   = r_skip ? '0 : ((|r_acc[95:80]) ? '1 : r_acc[79:16]);
    assign w_sq65   = {1'b0, r_sq} + {1'b0, w_addv};
    assign w_sq_new = w_sq65[SQ_W] ? '1 : w_sq65[SQ_W-1:0];

    // Sequencer next state.
    always_comb begin
        n_st   = r_st;
        o_done = 1'b0;
        unique case (r_st)
            CS_IDLE: if (i_start) n_st = CS_DIVM;
            CS_DIVM: if (w_last) n_st = CS_MEAN;
            CS_MEAN: n_st = CS_MUL;
            CS_MUL:  if (w_last) n_st = CS_ACC;
            CS_ACC:  n_st = (r_n < CNT_W'(2)) ? CS_DONE : CS_DIVV;
            CS_DIVV: if (w_last) n_st = CS_SQRT;
            CS_SQRT: if (w_last) n_st = CS_DONE;
            CS_DONE: begin
                o_done = 1'b1;
                n_st   = CS_IDLE;
            end
            default: n_st = CS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= CS_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_st)
            CS_IDLE: begin
                if (i_start) begin
                    r_x    <= w_x_in;
                    r_avg  <= i_req.avg;
                    r_sq   <= i_req.sq;
                    r_n    <= i_req.cnt;
                    r_div  <= i_req.cnt;
                    r_neg  <= w_delta[MEAN_W];
                    r_dmag <= w_delta[MEAN_W] ? w_dneg[MEAN_W-1:0] : w_delta[MEAN_W-1:0];
                    r_quo  <= {(w_delta[MEAN_W] ? w_dneg[MEAN_W-1:0]
                                                : w_delta[MEAN_W-1:0]), {FRAC{1'b0}}};
                    r_rem  <= '0;
                    r_cnt  <= 7'(MEAN_W);
                end
            end
            CS_DIVM, CS_DIVV: begin
                r_rem <= w_ge ? w_sum[CNT_W-1:0] : w_div_s[CNT_W-1:0];
                r_quo <= w_quo_nx;
                r_cnt <= r_cnt - 7'd1;
                if (r_st == CS_DIVV && w_last) begin
                    r_sqn   <= {w_quo_nx, {FRAC{1'b0}}};
                    r_sqrem <= '0;
                    r_root  <= '0;
                    r_cnt   <= 7'd40;
                end
            end
            CS_MEAN: begin
                r_avg  <= w_m;
                r_emag <= w_eneg_s ? w_eneg[MEAN_W-1:0] : w_e50[MEAN_W-1:0];
                r_skip <= (r_neg && w_epos) || (!r_neg && (r_dmag != '0) && w_eneg_s);
                r_acc  <= '0;
                r_cnt  <= 7'(MEAN_W);
            end
            CS_MUL: begin
                r_acc  <= {(r_dmag[0] ? w_sum[48:0] : {1'b0, r_acc[95:48]}), r_acc[47:1]};
                r_dmag <= r_dmag >> 1;
                r_cnt  <= r_cnt - 7'd1;
            end
            CS_ACC: begin
                r_sq  <= w_sq_new;
                r_quo <= w_sq_new;
                r_rem <= '0;
                r_div <= r_n - CNT_W'(1);
                r_cnt <= 7'd64;
                if (r_n < CNT_W'(2)) begin
                    r_std <= '0;
                end
            end
            CS_SQRT: begin
                r_sqrem <= w_ge ? w_sum[40:0] : w_sq_s[40:0];
                r_root  <= {r_root[38:0], w_ge};
                r_sqn   <= {r_sqn[77:0], 2'b00};
                r_cnt   <= r_cnt - 7'd1;
                if (w_last) begin
                    r_std <= STD_W'({r_root[38:0], w_ge});
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_res.avg   = r_avg;
    assign o_res.sq    = r_sq;
    assign o_res.stdev = r_std;

endmodule

FILE: sv/dual_channel_running_stats_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual channel running statistics sequencer
// Order: an ignored reading, flip or abort request passes from acceptance through
// the emit state into the result register. An accepted reading first runs the core
// (48 step mean divide, mean, 48 step multiply, accumulate, 64 step variance
// divide, 40 step square root, finish), then is handed over; the variance divide
// and square root are skipped while the channel has under two reads. One request
// at a time: input is ready once the result is registered, later if one is held.
// Reset is synchronous and active low; it restores the register defaults
// (target 10, final channel signal) and clears all statistics.
// ----------------------------------------------------------------------------
module dual_channel_running_stats_sequencer import drs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input requests.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // [31:0] freq
    input  logic [1:0]   s_axis_tuser,  // [1:0] mode
    // Results.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] signal_count, [31:16] pump_count, [79:32] signal_mean,
    // [127:80] signal_stdev, [128] signal_stdev_valid, [176:129] pump_mean,
    // [224:177] pump_stdev, [225] pump_stdev_valid, [231:226] zero
    output logic [231:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,  // [1:0] event_res
    // Configuration.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    t_top_st r_st, n_st;
    logic [CNT_W-1:0]         r_target;
    logic [1:0]               r_final;
    t_phase                   r_phase;
    logic                     r_abort;
    logic [CNT_W-1:0]         r_sc, r_pc;
    logic signed [MEAN_W-1:0] r_savg, r_pavg;
    logic [SQ_W-1:0]          r_ssq, r_psq;
    logic [STD_W-1:0]         r_sstd, r_pstd;
    logic                     r_ch;
    logic [1:0]               r_ev;
    logic                     r_out_valid;
    logic [231:0]             r_out_data;
    logic [1:0]               r_out_user;

    logic      w_acc, w_take, w_start, w_core_done, w_set_wait, w_cfg_wr;
    logic [1:0] w_ev;
    t_core_req w_req;
    t_core_res w_res;

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_TARGET) ? 32'(r_target) : 32'(r_final);

    assign s_axis_tready = (r_st == TS_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    // Request decode and event selection.
    logic [CNT_W-1:0] w_own, w_other, w_newc;
    logic             w_is_pump;
    always_comb begin
        w_is_pump  = (s_axis_tuser == MODE_PUMP);
        w_own      = w_is_pump ? r_pc : r_sc;
        w_other    = w_is_pump ? r_sc : r_pc;
        w_newc     = w_own + CNT_W'(1);
        w_take     = 1'b0;
        w_set_wait = 1'b0;
        w_ev       = EV_NONE;
        unique case (s_axis_tuser)
            MODE_SIGNAL, MODE_PUMP: begin
                if ((w_own < r_target) && (r_phase != PH_DONE)) begin
                    w_take = 1'b1;
                    if (w_newc < r_target) begin
                        w_ev = EV_NONE;
                    end else if (w_other < r_target) begin
                        w_ev = EV_FLIP;
                    end else if (r_final == (w_is_pump ? FINAL_PUMP : FINAL_SIGNAL)) begin
                        w_ev = EV_DONE;
                    end else begin
                        w_ev       = EV_FLIP;
                        w_set_wait = 1'b1;
                    end
                end
            end
            MODE_FLIP: begin
                if (r_phase == PH_WAITING) w_ev = r_abort ? EV_ABORTED : EV_DONE;
            end
            MODE_ABORT: w_ev = EV_ABORTED;
            default: w_ev = EV_NONE;
        endcase
    end

    assign w_start   = w_acc && w_take;
    assign w_req.avg  = w_is_pump ? r_pavg : r_savg;
    assign w_req.sq   = w_is_pump ? r_psq : r_ssq;
    assign w_req.cnt  = w_newc;
    assign w_req.freq = s_axis_tdata;

    drs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (w_req),
        .o_done  (w_core_done),
        .o_res   (w_res)
    );

    // Top level sequencer next state.
    logic w_emit;
    always_comb begin
        n_st   = r_st;
        w_emit = 1'b0;
        unique case (r_st)
            TS_IDLE: if (w_acc) n_st = w_take ? TS_CALC : TS_EMIT;
            TS_CALC: if (w_core_done) n_st = TS_EMIT;
            TS_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_emit = 1'b1;
                    n_st   = TS_IDLE;
                end
            end
            default: n_st = TS_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= TS_IDLE;
            r_target    <= CNT_W'(10);
            r_final     <= FINAL_SIGNAL;
            r_phase     <= PH_READING;
            r_abort     <= 1'b0;
            r_sc        <= '0;
            r_pc        <= '0;
            r_savg      <= '0;
            r_pavg      <= '0;
            r_ssq       <= '0;
            r_psq       <= '0;
            r_sstd      <= '0;
            r_pstd      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (w_cfg_wr) begin
                if (paddr[2] == REG_TARGET) r_target <= pwdata[CNT_W-1:0];
                else r_final <= pwdata[1:0];
            end
            if (w_acc) begin
                if (w_set_wait) r_phase <= PH_WAITING;
                if (s_axis_tuser == MODE_ABORT) begin
                    r_abort <= 1'b1;
                    r_phase <= PH_DONE;
                end
                if (w_take && !w_is_pump) r_sc <= w_newc;
                if (w_take && w_is_pump) r_pc <= w_newc;
            end
            // Write back the channel the core has just updated.
            if (r_st == TS_CALC && w_core_done) begin
                if (r_ch) begin
                    r_pavg <= w_res.avg;
                    r_psq  <= w_res.sq;
                    r_pstd <= w_res.stdev;
                end else begin
                    r_savg <= w_res.avg;
                    r_ssq  <= w_res.sq;
                    r_sstd <= w_res.stdev;
                end
            end
            if (w_emit) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ch <= w_is_pump;
            r_ev <= w_ev;
        end
        if (w_emit) begin
            r_out_user <= r_ev;
            r_out_data <= {6'b0, (r_pc >= CNT_W'(2)), r_pstd, r_pavg,
                           (r_sc >= CNT_W'(2)), r_sstd, r_savg, r_pc, r_sc};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // The block takes no request while the core is busy.
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == TS_CALC) |-> !s_axis_tready)
        else $error("input ready while core busy");

    // The core finishes only while a reading is in progress.
    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_core_done |-> (r_st == TS_CALC))
        else $error("core done outside calculation");

    // The signal channel with fewer than two reads has no deviation.
    a_sig_std_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sc < CNT_W'(2)) && (r_st == TS_IDLE) |-> (r_sstd == '0))
        else $error("signal stdev set below two reads");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running statistics sequencer testbench
// Drives signal, pump, flip and abort requests with bursty timing, predicts
// every result with a bit-accurate model of the Welford update, and compares
// each result against its prediction through a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;
    import drs_pkg::*;

    localparam int MAX_CYCLES = 3000000;

    typedef struct packed {
        logic [1:0]  ev;
        logic [15:0] sig_cnt;
        logic [15:0] pmp_cnt;
        logic [47:0] sig_mean;
        logic [47:0] sig_std;
        logic        sig_vld;
        logic [47:0] pmp_mean;
        logic [47:0] pmp_std;
        logic        pmp_vld;
    } t_stats;

    // Channel statistics held by the predictor.
    typedef struct {
        logic [15:0]        reads;
        logic signed [47:0] avg;
        logic [63:0]        sq;
    } t_chan;

    // Predictor of the sequencer, with its own state and registers.
    class stats_scoreboard;
        t_chan      sig, pmp;
        t_phase     phase;
        bit         aborted;
        logic [15:0] target;
        logic [1:0]  final_ch;
        t_stats     pending[$];
        int         mismatches;

        function void clear();
            sig = '{16'd0, 48'sd0, 64'd0};
            pmp = '{16'd0, 48'sd0, 64'd0};
            phase = PH_READING;
            aborted = 0;
            target = 16'd10;
            final_ch = FINAL_SIGNAL;
        endfunction

        function void write_reg(int idx, logic [31:0] v);
            if (idx == REG_TARGET) target = v[15:0];
            else final_ch = v[1:0];
        endfunction

        function void welford(ref t_chan c, input logic signed [31:0] f);
            logic signed [63:0]  x, delta, m, e;
            logic signed [127:0] p;
            logic [63:0]         add;
            logic [64:0]         s;
            c.reads = c.reads + 16'd1;
            x = 64'(f) <<< FRAC;
            delta = x - 64'(c.avg);
            m = 64'(c.avg) + delta / $signed({48'd0, c.reads});
            if (m > 64'sh7FFFFFFFFFFF) m = 64'sh7FFFFFFFFFFF;
            if (m < -64'sh800000000000) m = -64'sh800000000000;
            c.avg = m[47:0];
            e = x - m;
            if ((delta < 0 && e > 0) || (delta > 0 && e < 0)) return;
            p = (128'(delta) * 128'(e)) >>> FRAC;
            add = (p[127:64] != 0) ? '1 : p[63:0];
            s = {1'b0, c.sq} + {1'b0, add};
            c.sq = s[64] ? '1 : s[63:0];
        endfunction

        function logic [47:0] stdev(logic [15:0] n, logic [63:0] sq);
            logic [63:0]  v, r, t;
            logic [127:0] num;
            if (n < 2) return 0;
            v = sq / (n - 16'd1);
            num = {64'd0, v} << FRAC;
            r = 0;
            for (int b = 63; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (128'(t) * 128'(t) <= num) r = t;
            end
            return r[47:0];
        endfunction

        function logic [1:0] take(ref t_chan own, input logic [15:0] other,
                                  input logic [1:0] me, input logic [31:0] f);
            if (!(own.reads < target) || phase == PH_DONE) return EV_NONE;
            welford(own, f);
            if (own.reads < target) return EV_NONE;
            if (other < target) return EV_FLIP;
            if (final_ch == me) return EV_DONE;
            phase = PH_WAITING;
            return EV_FLIP;
        endfunction

        function void note_request(logic [1:0] mode, logic [31:0] f);
            t_stats r;
            case (mode)
                MODE_SIGNAL: r.ev = take(sig, pmp.reads, FINAL_SIGNAL, f);
                MODE_PUMP:   r.ev = take(pmp, sig.reads, FINAL_PUMP, f);
                MODE_FLIP: begin
                    r.ev = (phase == PH_WAITING) ? (aborted ? EV_ABORTED : EV_DONE)
                                                 : EV_NONE;
                end
                default: begin
                    aborted = 1;
                    phase = PH_DONE;
                    r.ev = EV_ABORTED;
                end
            endcase
            r.sig_cnt = sig.reads;
            r.pmp_cnt = pmp.reads;
            r.sig_mean = sig.avg;
            r.sig_std = stdev(sig.reads, sig.sq);
            r.sig_vld = sig.reads >= 2;
            r.pmp_mean = pmp.avg;
            r.pmp_std = stdev(pmp.reads, pmp.sq);
            r.pmp_vld = pmp.reads >= 2;
            pending.push_back(r);
        endfunction

        function void check_result(t_stats got);
            t_stats w;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            w = pending.pop_front();
            if (got !== w) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch ev %0d/%0d cnt %0d,%0d/%0d,%0d", w.ev, got.ev,
                             w.sig_cnt, w.pmp_cnt, got.sig_cnt, got.pmp_cnt);
                    $display("  smean %h/%h sstd %h/%h sv %b/%b", w.sig_mean,
                             got.sig_mean, w.sig_std, got.sig_std, w.sig_vld, got.sig_vld);
                    $display("  pmean %h/%h pstd %h/%h pv %b/%b", w.pmp_mean,
                             got.pmp_mean, w.pmp_std, got.pmp_std, w.pmp_vld, got.pmp_vld);
                end
            end
        endfunction
    endclass

    logic         i_clk = 0, i_rst_n = 0;
    logic         s_axis_tvalid = 0, s_axis_tready;
    logic [31:0]  s_axis_tdata = 0;
    logic [1:0]   s_axis_tuser = 0;
    logic         m_axis_tvalid, m_axis_tready = 0;
    logic [231:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [2:0]   paddr = 0;
    logic [31:0]  pwdata = 0, prdata;
    logic         pready;
    stats_scoreboard sb = new();
    int  cycles = 0;
    int  hold_off = 0;
    bit  stall_mode = 0;

    dual_channel_running_stats_sequencer dut (.*);

    always #10 i_clk = ~i_clk;

    // Timeout guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Unpack one result into its fields.
    function automatic t_stats pack(logic [1:0] u, logic [231:0] d);
        t_stats r;
        r.ev = u;
        r.sig_cnt = d[15:0];
        r.pmp_cnt = d[31:16];
        r.sig_mean = d[79:32];
        r.sig_std = d[127:80];
        r.sig_vld = d[128];
        r.pmp_mean = d[176:129];
        r.pmp_std = d[224:177];
        r.pmp_vld = d[225];
        return r;
    endfunction

    // Result sampling.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(pack(m_axis_tuser, m_axis_tdata));
    end

    // Receiver back-pressure: own pattern, with a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 0;
        end else if (stall_mode) begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end else begin
            m_axis_tready <= 1;
        end
    end

    task automatic reg_write(int idx, logic [31:0] v);
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= 3'(idx * 4); pwdata <= v;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, v);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send(logic [1:0] mode, logic [31:0] f);
        @(negedge i_clk);
        s_axis_tvalid <= 1; s_axis_tuser <= mode; s_axis_tdata <= f;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(mode, f);
        if ($urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Frequency picks: either extreme, small values around zero, or anything.
    function automatic logic [31:0] rand_freq(int kind);
        case (kind)
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    task automatic phase_run(logic [15:0] tgt, logic [1:0] fin, int n);
        logic [1:0] m;
        reg_write(REG_TARGET, {16'd0, tgt});
        reg_write(REG_FINAL, {30'd0, fin});
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0: m = MODE_FLIP;
                default: m = 2'($urandom_range(0, 1));
            endcase
            send(m, rand_freq($urandom_range(0, 5)));
        end
        drain();
    endtask

    initial begin
        sb.clear();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes into the default setting, flip outside waiting.
        send(MODE_FLIP, 0);
        send(MODE_SIGNAL, 32'h7FFFFFFF);
        send(MODE_SIGNAL, 32'h80000000);
        send(MODE_PUMP, 32'h80000000);
        send(MODE_PUMP, 32'h7FFFFFFF);
        send(MODE_SIGNAL, 32'hFFFFFFFF);
        send(MODE_PUMP, 32'h00000001);
        drain();
        // Small target, final channel neither: reach waiting, repeat flips.
        reg_write(REG_TARGET, 32'hFFFF0004);
        reg_write(REG_FINAL, 32'd2);
        for (int i = 0; i < 3; i++) send(MODE_PUMP, rand_freq(3));
        send(MODE_PUMP, 32'h12345678);
        send(MODE_SIGNAL, 0);
        send(MODE_FLIP, 0);
        send(MODE_FLIP, 0);
        drain();

        // Long receiver hold-off while the sender keeps offering.
        reg_write(REG_TARGET, 32'd600);
        reg_write(REG_FINAL, 32'd3);
        hold_off = 3000;
        phase_run(16'd600, 2'd3, 40);

        // Random bulk with stalls; the larger targets stay ahead of the counts so that
        // readings are mostly accepted until each target is met.
        stall_mode = 1;
        phase_run(16'd900, FINAL_PUMP, 700);
        phase_run(16'd1300, FINAL_SIGNAL, 900);
        phase_run(16'd0, 2'd2, 30);
        phase_run(16'hFFFF, FINAL_SIGNAL, 200);
        phase_run(16'd1, FINAL_PUMP, 20);
        stall_mode = 0;

        // Abort, repeated abort, then requests in the done phase.
        send(MODE_ABORT, $urandom);
        send(MODE_ABORT, 0);
        send(MODE_SIGNAL, 5);
        send(MODE_FLIP, 0);
        drain();
        reg_write(REG_TARGET, 32'hFFFF);
        for (int i = 0; i < 100; i++) send(2'($urandom_range(0, 3)), $urandom);
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

FILE: files.f
sv/drs_pkg.sv
sv/drs_core.sv
sv/dual_channel_running_stats_sequencer.sv
test/tb_top.sv
